>>> hw/rtl/palette_yuv_to_rgb_gamma_unit_defines.svh
// Assertion macros for the palette color conversion unit.
// Used by the checker; needs clk_i and rst_ni in the scope of each use.
`ifndef PALETTE_YUV_TO_RGB_GAMMA_UNIT_DEFINES_SVH
`define PALETTE_YUV_TO_RGB_GAMMA_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PYRG_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pyrg: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define PYRG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pyrg: next-cycle check failed");

`endif

>>> hw/rtl/pyrg_pkg.sv
// Package for the palette color conversion unit: codes, ROM contents and
// fixed-point constants. No dependencies.
`timescale 1ns / 1ps

package pyrg_pkg;

  typedef enum logic {
    CmdLoad    = 1'b0,
    CmdConvert = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    CfgSaturation = 2'd0,
    CfgContrast   = 2'd1,
    CfgBrightness = 2'd2,
    CfgLumaSelect = 2'd3
  } cfg_idx_e;

  localparam int unsigned GammaEntries = 256;
  localparam int unsigned GammaAw      = $clog2(GammaEntries);

  // Luma: yi = trunc(32*C*X / 15625), X = 125*Y + 16*(B - 1000).
  localparam logic [13:0] YDivisor  = 14'd15625;
  localparam logic [18:0] YRecip    = 19'd274877;   // floor(2^32 / 15625)
  localparam int          YShift    = 32;
  // Chroma: ui = trunc(C*S*Us / 781250).
  localparam logic [19:0] UvDivisor = 20'd781250;
  localparam logic [16:0] UvRecip   = 17'd87960;    // floor(2^36 / 781250)
  localparam int          UvShift   = 36;

  localparam logic [8:0] LumaNewRom [16] = '{
    9'd0,   9'd256, 9'd74,  9'd163, 9'd92,  9'd128, 9'd56,  9'd199,
    9'd92,  9'd56,  9'd128, 9'd74,  9'd117, 9'd199, 9'd117, 9'd163
  };

  localparam logic [8:0] LumaOldRom [16] = '{
    9'd0,   9'd256, 9'd56,  9'd191, 9'd128, 9'd128, 9'd56,  9'd191,
    9'd128, 9'd56,  9'd128, 9'd56,  9'd128, 9'd191, 9'd128, 9'd191
  };

  // Chroma in hundredths.
  localparam logic signed [14:0] URom [16] = '{
    15'sd0,     15'sd0,     -15'sd3105, 15'sd3105,
    15'sd5737,  -15'sd5737, 15'sd8114,  -15'sd8114,
    -15'sd5737, -15'sd7496, -15'sd3105, 15'sd0,
    15'sd0,     -15'sd5737, 15'sd8114,  15'sd0
  };

  localparam logic signed [14:0] VRom [16] = '{
    15'sd0,     15'sd0,     15'sd4214,  -15'sd4214,
    15'sd3225,  -15'sd3225, 15'sd0,     15'sd0,
    15'sd3225,  15'sd1745,  15'sd4214,  15'sd0,
    15'sd0,     -15'sd3225, 15'sd0,     15'sd0
  };

  localparam logic [3:0] DitherRom [16] = '{
    4'h0, 4'hE, 4'h4, 4'hC, 4'h8, 4'h4, 4'h4, 4'hC,
    4'h4, 4'h4, 4'h8, 4'h4, 4'h8, 4'h8, 4'h8, 4'hC
  };

endpackage

>>> hw/rtl/palette_yuv_to_rgb_gamma_unit.sv
// Palette pair to gamma corrected RGB conversion, fully pipelined.
// Depends on pyrg_pkg for codes, ROM tables and divider constants.
`timescale 1ns / 1ps

// Channel   Direction  Handshake               Payload
// config    in         cfg_we_i                cfg_idx_i, cfg_data_i
// items     in         in_valid_i/in_stall_o   command_i, gamma_*_i, *_color_i
// results   out        out_valid_o/out_stall_i red/green/blue, dither, luma, u, v
//
// One transaction is accepted every clock while in_stall_o is low. A convert
// passes nine register ranks, the first loaded at the accepting edge. Load
// transactions write the gamma memories and give no result. Reset clears the
// valid bits and sets the configuration registers to their defaults; the gamma
// memories are not cleared and must be loaded before they are read. A held
// result freezes all ranks, so in_stall_o follows a stalled output.
module palette_yuv_to_rgb_gamma_unit (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration writes
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_idx_i,
  input  logic [10:0]            cfg_data_i,
  // input transactions
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   command_i,
  input  logic [7:0]             gamma_index_i,
  input  logic [7:0]             gamma_value_i,
  input  logic [3:0]             first_color_i,
  input  logic [3:0]             second_color_i,
  // result transactions
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [7:0]             red_o,
  output logic [7:0]             green_o,
  output logic [7:0]             blue_o,
  output logic [3:0]             dither_code_o,
  output logic signed [18:0]     luma_scaled_o,
  output logic signed [15:0]     u_scaled_o,
  output logic signed [15:0]     v_scaled_o
);
  import pyrg_pkg::*;

  // Fields that ride along with every transaction until the memory rank.
  typedef struct packed {
    cmd_e                 cmd;
    logic [GammaAw-1:0]   gidx;
    logic [7:0]           gval;
    logic [3:0]           dither;
  } carry_t;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [10:0] sat_q, con_q, bri_q;
  logic        luma_sel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_q      <= 11'd1000;
      con_q      <= 11'd1000;
      bri_q      <= 11'd1000;
      luma_sel_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgSaturation: sat_q      <= cfg_data_i;
        CfgContrast:   con_q      <= cfg_data_i;
        CfgBrightness: bri_q      <= cfg_data_i;
        CfgLumaSelect: luma_sel_q <= cfg_data_i[0];
        default:       ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control: every rank moves together unless the result register is held.
  // ---------------------------------------------------------------------------
  logic       out_valid_q;
  logic       advance;
  logic [7:0] vld_q, vld_d;

  assign advance    = !(out_valid_q && out_stall_i);
  assign in_stall_o = !advance;

  // ---------------------------------------------------------------------------
  // Rank 1: ROM lookups, luma numerator and chroma sums.
  // ---------------------------------------------------------------------------
  carry_t             s1_carry_d, s1_carry_q;
  logic        [8:0]  luma_rom;
  logic        [17:0] x_raw;
  logic signed [17:0] s1_x_d, s1_x_q;
  logic signed [15:0] s1_us_d, s1_us_q, s1_vs_d, s1_vs_q;

  always_comb begin
    luma_rom          = luma_sel_q ? LumaNewRom[first_color_i] : LumaOldRom[first_color_i];
    x_raw             = 18'(luma_rom) * 18'd125 + 18'({bri_q, 4'b0000}) - 18'd16000;
    s1_x_d            = $signed(x_raw);
    s1_us_d           = 16'(URom[first_color_i]) + 16'(URom[second_color_i]);
    s1_vs_d           = 16'(VRom[first_color_i]) + 16'(VRom[second_color_i]);
    s1_carry_d.cmd    = cmd_e'(command_i);
    s1_carry_d.gidx   = gamma_index_i;
    s1_carry_d.gval   = gamma_value_i;
    s1_carry_d.dither = DitherRom[first_color_i];
  end

  // ---------------------------------------------------------------------------
  // Rank 2: magnitudes and the first products.
  // ---------------------------------------------------------------------------
  carry_t      s2_carry_q;
  logic [17:0] x_abs_w;
  logic [15:0] us_abs_w, vs_abs_w;
  logic        s2_yneg_d, s2_yneg_q, s2_uneg_d, s2_uneg_q, s2_vneg_d, s2_vneg_q;
  logic [31:0] s2_yn_d, s2_yn_q;
  logic [21:0] s2_cs_d, s2_cs_q;
  logic [13:0] s2_us_abs_d, s2_us_abs_q, s2_vs_abs_d, s2_vs_abs_q;

  always_comb begin
    x_abs_w     = s1_x_q[17] ? 18'(-s1_x_q) : 18'(s1_x_q);
    us_abs_w    = s1_us_q[15] ? 16'(-s1_us_q) : 16'(s1_us_q);
    vs_abs_w    = s1_vs_q[15] ? 16'(-s1_vs_q) : 16'(s1_vs_q);
    s2_yneg_d   = s1_x_q[17];
    s2_uneg_d   = s1_us_q[15];
    s2_vneg_d   = s1_vs_q[15];
    s2_yn_d     = {27'(con_q * x_abs_w[15:0]), 5'b00000};
    s2_cs_d     = 22'(con_q * sat_q);
    s2_us_abs_d = us_abs_w[13:0];
    s2_vs_abs_d = vs_abs_w[13:0];
  end

  // ---------------------------------------------------------------------------
  // Rank 3: luma quotient estimate, chroma numerators.
  // ---------------------------------------------------------------------------
  carry_t      s3_carry_q;
  logic [50:0] yq_prod;
  logic        s3_yneg_q, s3_uneg_q, s3_vneg_q;
  logic [31:0] s3_yn_q;
  logic [18:0] s3_yq0_d, s3_yq0_q;
  logic [35:0] s3_un_d, s3_un_q, s3_vn_d, s3_vn_q;

  always_comb begin
    yq_prod  = 51'(s2_yn_q) * 51'(YRecip);
    s3_yq0_d = yq_prod[YShift +: 19];
    s3_un_d  = 36'(s2_cs_q) * 36'(s2_us_abs_q);
    s3_vn_d  = 36'(s2_cs_q) * 36'(s2_vs_abs_q);
  end

  // ---------------------------------------------------------------------------
  // Rank 4: luma back product, chroma quotient estimates.
  // ---------------------------------------------------------------------------
  carry_t      s4_carry_q;
  logic [52:0] uq_prod, vq_prod;
  logic        s4_yneg_q, s4_uneg_q, s4_vneg_q;
  logic [31:0] s4_yn_q, s4_yprod_d, s4_yprod_q;
  logic [18:0] s4_yq0_q;
  logic [35:0] s4_un_q, s4_vn_q;
  logic [16:0] s4_uq0_d, s4_uq0_q, s4_vq0_d, s4_vq0_q;

  always_comb begin
    s4_yprod_d = 32'(33'(s3_yq0_q) * 33'(YDivisor));
    uq_prod    = 53'(s3_un_q) * 53'(UvRecip);
    vq_prod    = 53'(s3_vn_q) * 53'(UvRecip);
    s4_uq0_d   = uq_prod[UvShift +: 17];
    s4_vq0_d   = vq_prod[UvShift +: 17];
  end

  // ---------------------------------------------------------------------------
  // Rank 5: luma correction and sign, chroma back products.
  // ---------------------------------------------------------------------------
  carry_t             s5_carry_q;
  logic        [31:0] y_rem;
  logic        [18:0] y_quot;
  logic signed [18:0] s5_yi_d, s5_yi_q;
  logic               s5_uneg_q, s5_vneg_q;
  logic        [35:0] s5_un_q, s5_vn_q, s5_uprod_d, s5_uprod_q, s5_vprod_d, s5_vprod_q;
  logic        [16:0] s5_uq0_q, s5_vq0_q;

  always_comb begin
    // The estimate is never high and at most one below the true quotient.
    y_rem      = s4_yn_q - s4_yprod_q;
    y_quot     = s4_yq0_q + 19'(y_rem >= 32'(YDivisor));
    s5_yi_d    = s4_yneg_q ? $signed(19'(-y_quot)) : $signed(y_quot);
    s5_uprod_d = 36'(37'(s4_uq0_q) * 37'(UvDivisor));
    s5_vprod_d = 36'(37'(s4_vq0_q) * 37'(UvDivisor));
  end

  // ---------------------------------------------------------------------------
  // Rank 6: chroma correction and sign.
  // ---------------------------------------------------------------------------
  carry_t             s6_carry_q;
  logic        [35:0] u_rem, v_rem;
  logic        [16:0] u_quot, v_quot;
  logic signed [18:0] s6_yi_q;
  logic signed [17:0] s6_ui_d, s6_ui_q, s6_vi_d, s6_vi_q;

  always_comb begin
    u_rem   = s5_un_q - s5_uprod_q;
    v_rem   = s5_vn_q - s5_vprod_q;
    u_quot  = s5_uq0_q + 17'(u_rem >= 36'(UvDivisor));
    v_quot  = s5_vq0_q + 17'(v_rem >= 36'(UvDivisor));
    s6_ui_d = s5_uneg_q ? $signed(18'(-u_quot)) : $signed(18'(u_quot));
    s6_vi_d = s5_vneg_q ? $signed(18'(-v_quot)) : $signed(18'(v_quot));
  end

  // ---------------------------------------------------------------------------
  // Rank 7: RGB sums and scaled chroma outputs.
  // green = 436*Y - 130*R - 50*B reduces to 256*Y - 130*V - 50*U.
  // ---------------------------------------------------------------------------
  carry_t             s7_carry_q;
  logic signed [19:0] u_tri, v_tri;
  logic signed [18:0] s7_yi_q;
  logic signed [19:0] s7_sum_r_d, s7_sum_r_q, s7_sum_b_d, s7_sum_b_q;
  logic signed [27:0] s7_sum_g_d, s7_sum_g_q;
  logic signed [15:0] s7_u3_d, s7_u3_q, s7_v3_d, s7_v3_q;

  always_comb begin
    s7_sum_r_d = 20'(s6_vi_q) + 20'(s6_yi_q);
    s7_sum_b_d = 20'(s6_ui_q) + 20'(s6_yi_q);
    s7_sum_g_d = (28'(s6_yi_q) <<< 8) - 28'(s6_vi_q) * 28'sd130 - 28'(s6_ui_q) * 28'sd50;
    u_tri      = 20'(s6_ui_q) * 20'sd3;
    v_tri      = 20'(s6_vi_q) * 20'sd3;
    // Arithmetic shift right by three, kept to 16 bits.
    s7_u3_d    = $signed(u_tri[18:3]);
    s7_v3_d    = $signed(v_tri[18:3]);
  end

  // ---------------------------------------------------------------------------
  // Rank 8: gamma memories. Loads write and converts read at this same rank,
  // so table accesses happen in transaction order and need no forwarding.
  // Red and blue share a two-read-port copy, green has its own copy.
  // ---------------------------------------------------------------------------
  logic [7:0]         gamma_rb_mem [GammaEntries];
  logic [7:0]         gamma_g_mem  [GammaEntries];
  logic [GammaAw-1:0] r_addr, g_addr, b_addr;
  logic               s8_r_lo_d, s8_r_hi_d, s8_g_lo_d, s8_g_hi_d, s8_b_lo_d, s8_b_hi_d;
  logic               s8_r_lo_q, s8_r_hi_q, s8_g_lo_q, s8_g_hi_q, s8_b_lo_q, s8_b_hi_q;
  logic [7:0]         s8_r_rd_q, s8_g_rd_q, s8_b_rd_q;
  logic [3:0]         s8_dither_q;
  logic signed [18:0] s8_yi_q;
  logic signed [15:0] s8_u3_q, s8_v3_q;

  always_comb begin
    // After the floor shift, a channel level below 0 or above 255 clamps.
    r_addr    = s7_sum_r_q[15:8];
    b_addr    = s7_sum_b_q[15:8];
    g_addr    = s7_sum_g_q[23:16];
    s8_r_lo_d = s7_sum_r_q[19];
    s8_r_hi_d = !s7_sum_r_q[19] && (s7_sum_r_q[18:16] != 3'd0);
    s8_b_lo_d = s7_sum_b_q[19];
    s8_b_hi_d = !s7_sum_b_q[19] && (s7_sum_b_q[18:16] != 3'd0);
    s8_g_lo_d = s7_sum_g_q[27];
    s8_g_hi_d = !s7_sum_g_q[27] && (s7_sum_g_q[26:24] != 3'd0);
  end

  always_ff @(posedge clk_i) begin
    if (advance && vld_q[6] && (s7_carry_q.cmd == CmdLoad)) begin
      gamma_rb_mem[s7_carry_q.gidx] <= s7_carry_q.gval;
      gamma_g_mem[s7_carry_q.gidx]  <= s7_carry_q.gval;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s8_r_rd_q <= gamma_rb_mem[r_addr];
      s8_b_rd_q <= gamma_rb_mem[b_addr];
      s8_g_rd_q <= gamma_g_mem[g_addr];
    end
  end

  // ---------------------------------------------------------------------------
  // Result register: clamp selection over the memory data.
  // ---------------------------------------------------------------------------
  logic [7:0] red_d, green_d, blue_d;
  logic [7:0] red_q, green_q, blue_q;
  logic [3:0] dither_q;
  logic signed [18:0] luma_q;
  logic signed [15:0] u_q, v_q;

  always_comb begin
    red_d   = s8_r_lo_q ? 8'd0 : (s8_r_hi_q ? 8'hFF : s8_r_rd_q);
    green_d = s8_g_lo_q ? 8'd0 : (s8_g_hi_q ? 8'hFF : s8_g_rd_q);
    blue_d  = s8_b_lo_q ? 8'd0 : (s8_b_hi_q ? 8'hFF : s8_b_rd_q);
  end

  // ---------------------------------------------------------------------------
  // Valid bits. Rank 8 and the result register carry converts only.
  // ---------------------------------------------------------------------------
  always_comb begin
    vld_d      = {vld_q[6:0], in_valid_i};
    vld_d[7]   = vld_q[6] && (s7_carry_q.cmd == CmdConvert);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      vld_q       <= vld_d;
      out_valid_q <= vld_q[7];
    end
  end

  // Datapath registers, no reset.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_carry_q  <= s1_carry_d;
      s1_x_q      <= s1_x_d;
      s1_us_q     <= s1_us_d;
      s1_vs_q     <= s1_vs_d;

      s2_carry_q  <= s1_carry_q;
      s2_yneg_q   <= s2_yneg_d;
      s2_uneg_q   <= s2_uneg_d;
      s2_vneg_q   <= s2_vneg_d;
      s2_yn_q     <= s2_yn_d;
      s2_cs_q     <= s2_cs_d;
      s2_us_abs_q <= s2_us_abs_d;
      s2_vs_abs_q <= s2_vs_abs_d;

      s3_carry_q  <= s2_carry_q;
      s3_yneg_q   <= s2_yneg_q;
      s3_uneg_q   <= s2_uneg_q;
      s3_vneg_q   <= s2_vneg_q;
      s3_yn_q     <= s2_yn_q;
      s3_yq0_q    <= s3_yq0_d;
      s3_un_q     <= s3_un_d;
      s3_vn_q     <= s3_vn_d;

      s4_carry_q  <= s3_carry_q;
      s4_yneg_q   <= s3_yneg_q;
      s4_uneg_q   <= s3_uneg_q;
      s4_vneg_q   <= s3_vneg_q;
      s4_yn_q     <= s3_yn_q;
      s4_yprod_q  <= s4_yprod_d;
      s4_yq0_q    <= s3_yq0_q;
      s4_un_q     <= s3_un_q;
      s4_vn_q     <= s3_vn_q;
      s4_uq0_q    <= s4_uq0_d;
      s4_vq0_q    <= s4_vq0_d;

      s5_carry_q  <= s4_carry_q;
      s5_yi_q     <= s5_yi_d;
      s5_uneg_q   <= s4_uneg_q;
      s5_vneg_q   <= s4_vneg_q;
      s5_un_q     <= s4_un_q;
      s5_vn_q     <= s4_vn_q;
      s5_uq0_q    <= s4_uq0_q;
      s5_vq0_q    <= s4_vq0_q;
      s5_uprod_q  <= s5_uprod_d;
      s5_vprod_q  <= s5_vprod_d;

      s6_carry_q  <= s5_carry_q;
      s6_yi_q     <= s5_yi_q;
      s6_ui_q     <= s6_ui_d;
      s6_vi_q     <= s6_vi_d;

      s7_carry_q  <= s6_carry_q;
      s7_yi_q     <= s6_yi_q;
      s7_sum_r_q  <= s7_sum_r_d;
      s7_sum_g_q  <= s7_sum_g_d;
      s7_sum_b_q  <= s7_sum_b_d;
      s7_u3_q     <= s7_u3_d;
      s7_v3_q     <= s7_v3_d;

      s8_r_lo_q   <= s8_r_lo_d;
      s8_r_hi_q   <= s8_r_hi_d;
      s8_g_lo_q   <= s8_g_lo_d;
      s8_g_hi_q   <= s8_g_hi_d;
      s8_b_lo_q   <= s8_b_lo_d;
      s8_b_hi_q   <= s8_b_hi_d;
      s8_dither_q <= s7_carry_q.dither;
      s8_yi_q     <= s7_yi_q;
      s8_u3_q     <= s7_u3_q;
      s8_v3_q     <= s7_v3_q;

      red_q       <= red_d;
      green_q     <= green_d;
      blue_q      <= blue_d;
      dither_q    <= s8_dither_q;
      luma_q      <= s8_yi_q;
      u_q         <= s8_u3_q;
      v_q         <= s8_v3_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign red_o         = red_q;
  assign green_o       = green_q;
  assign blue_o        = blue_q;
  assign dither_code_o = dither_q;
  assign luma_scaled_o = luma_q;
  assign u_scaled_o    = u_q;
  assign v_scaled_o    = v_q;

endmodule

>>> hw/rtl/pyrg_checker.sv
// Port-level checker for the palette color conversion unit, bound to the top.
// Depends on pyrg_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "palette_yuv_to_rgb_gamma_unit_defines.svh"

module pyrg_checker (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_stall_o,
  input  logic                   command_i,
  input  logic                   out_valid_o,
  input  logic                   out_stall_i,
  input  logic [7:0]             red_o,
  input  logic [7:0]             green_o,
  input  logic [7:0]             blue_o,
  input  logic [3:0]             dither_code_o,
  input  logic signed [18:0]     luma_scaled_o,
  input  logic signed [15:0]     u_scaled_o,
  input  logic signed [15:0]     v_scaled_o
);
  import pyrg_pkg::*;

  logic        in_conv_fire;
  logic        out_fire;
  logic [4:0]  pending_q, pending_d;
  logic [78:0] out_payload;

  assign in_conv_fire = in_valid_i && !in_stall_o && (command_i == CmdConvert);
  assign out_fire     = out_valid_o && !out_stall_i;

  // All result fields in one vector so a held result can be checked at once.
  assign out_payload = {red_o, green_o, blue_o, dither_code_o,
                        luma_scaled_o, u_scaled_o, v_scaled_o};

  // Converts accepted whose results have not yet been taken.
  always_comb begin
    pending_d = pending_q + 5'(in_conv_fire) - 5'(out_fire);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  `PYRG_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_payload))
  `PYRG_ASSERT_NOW(a_stall_back, out_valid_o && out_stall_i, in_stall_o)
  `PYRG_ASSERT_NOW(a_stall_cause, in_stall_o, out_valid_o && out_stall_i)
  `PYRG_ASSERT_NOW(a_no_phantom, out_fire, pending_q != 5'd0)

endmodule

bind palette_yuv_to_rgb_gamma_unit pyrg_checker u_pyrg_checker (.*);

>>> bench/palette_yuv_to_rgb_gamma_unit_test.sv
// Self-checking testbench for palette_yuv_to_rgb_gamma_unit: directed and random
// transactions are checked against an in-bench color conversion predictor.
// Depends on pyrg_pkg for the command and register index codes.
`timescale 1ns / 1ps

module palette_yuv_to_rgb_gamma_unit_test;
  import pyrg_pkg::*;

  // Per palette color: new luma, old luma, U and V in hundredths, dither code.
  localparam int LUMA_NEW [16] = '{0, 256, 74, 163, 92, 128, 56, 199,
                                   92, 56, 128, 74, 117, 199, 117, 163};
  localparam int LUMA_OLD [16] = '{0, 256, 56, 191, 128, 128, 56, 191,
                                   128, 56, 128, 56, 128, 191, 128, 191};
  localparam int CHROMA_U [16] = '{0, 0, -3105, 3105, 5737, -5737, 8114, -8114,
                                   -5737, -7496, -3105, 0, 0, -5737, 8114, 0};
  localparam int CHROMA_V [16] = '{0, 0, 4214, -4214, 3225, -3225, 0, 0,
                                   3225, 1745, 4214, 0, 0, -3225, 0, 0};
  localparam logic [3:0] DITHER [16] = '{4'h0, 4'hE, 4'h4, 4'hC, 4'h8, 4'h4, 4'h4, 4'hC,
                                         4'h4, 4'h4, 4'h8, 4'h4, 4'h8, 4'h8, 4'h8, 4'hC};

  // Directed color pairs, first color in the upper nibble.
  localparam logic [7:0] DIRECTED_PAIRS [16] = '{8'h00, 8'h11, 8'hFF, 8'h0F, 8'hF0, 8'h10,
                                                 8'h23, 8'h45, 8'h67, 8'h89, 8'hAB, 8'hCD,
                                                 8'hE6, 8'h9E, 8'h09, 8'h19};

  localparam int RANDOM_PHASES    = 7;
  localparam int ITEMS_PER_PHASE  = 96;
  localparam int LONG_HOLD_CYCLES = 60;
  // Ample room for trailing transactions to drain from the unit.
  localparam int DRAIN_CYCLES     = 16;

  typedef struct packed {
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [3:0]         dither;
    logic signed [18:0] luma;
    logic signed [15:0] u_val;
    logic signed [15:0] v_val;
  } pixel_t;

  // Keeps a shadow of the gamma memory and the registers, predicts each
  // converted pixel when its transaction is accepted and checks the results.
  class rgb_conversion_tracker;
    pixel_t      expected_pixels[$];
    logic [7:0]  gamma_shadow[256];
    bit          gamma_loaded[256];
    int          saturation = 1000;
    int          contrast   = 1000;
    int          brightness = 1000;
    bit          new_luma   = 1'b1;
    int unsigned failures;
    int unsigned pixels_checked;
    int unsigned converts_seen;
    int unsigned loads_seen;

    function longint floor_div(longint x, longint d);
      longint q;
      q = x / d;
      if (x < 0 && x % d != 0) q--;
      return q;
    endfunction

    // Levels outside 0..255 clamp; the rest go through the gamma memory.
    function logic [7:0] shade(longint lvl);
      if (lvl < 0) return 8'd0;
      if (lvl > 255) return 8'd255;
      return gamma_shadow[lvl[7:0]];
    endfunction

    function void set_reg(cfg_idx_e idx, logic [10:0] value);
      case (idx)
        CfgSaturation: saturation = value;
        CfgContrast:   contrast   = value;
        CfgBrightness: brightness = value;
        CfgLumaSelect: new_luma   = value[0];
        default: ;
      endcase
    endfunction

    // Exact integer version of the conversion; divisions truncate toward zero
    // and the channel shifts round toward minus infinity.
    function void convert_pair(input logic [3:0] fc, input logic [3:0] sc,
                               output pixel_t px, output longint lvl_r,
                               output longint lvl_g, output longint lvl_b);
      longint c, s, y, us, vs, yi, ui, vi, r_sum, g_sum, b_sum, u3, v3;
      c = contrast;
      s = saturation;
      y = new_luma ? LUMA_NEW[fc] : LUMA_OLD[fc];
      us = longint'(CHROMA_U[fc]) + CHROMA_U[sc];
      vs = longint'(CHROMA_V[fc]) + CHROMA_V[sc];
      yi = (256 * c * (1000 * y + 128 * (longint'(brightness) - 1000))) / 1000000;
      ui = (256 * c * s * us) / 200000000;
      vi = (256 * c * s * vs) / 200000000;
      b_sum = ui + yi;
      r_sum = vi + yi;
      g_sum = 436 * yi - 130 * r_sum - 50 * b_sum;
      lvl_r = floor_div(r_sum, 256);
      lvl_g = floor_div(g_sum, 65536);
      lvl_b = floor_div(b_sum, 256);
      u3 = floor_div(ui * 3, 8);
      v3 = floor_div(vi * 3, 8);
      px.red    = shade(lvl_r);
      px.green  = shade(lvl_g);
      px.blue   = shade(lvl_b);
      px.dither = DITHER[fc];
      px.luma   = yi[18:0];
      px.u_val  = u3[15:0];
      px.v_val  = v3[15:0];
    endfunction

    function void accept_item(cmd_e cmd, logic [7:0] gidx, logic [7:0] gval,
                              logic [3:0] fc, logic [3:0] sc);
      pixel_t px;
      longint lr, lg, lb;
      if (cmd == CmdLoad) begin
        gamma_shadow[gidx] = gval;
        gamma_loaded[gidx] = 1'b1;
        loads_seen++;
      end else begin
        convert_pair(fc, sc, px, lr, lg, lb);
        expected_pixels.push_back(px);
        converts_seen++;
      end
    endfunction

    function void note_failure(string msg);
      if (failures < 10) $display("MISMATCH: %s", msg);
      failures++;
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      pixels_checked++;
      if (expected_pixels.size() == 0) begin
        note_failure($sformatf("result %0d arrived with nothing expected", pixels_checked));
        return;
      end
      want = expected_pixels.pop_front();
      if (got.red !== want.red)
        note_failure($sformatf("result %0d red: expected %0d, got %0d",
                               pixels_checked, want.red, got.red));
      if (got.green !== want.green)
        note_failure($sformatf("result %0d green: expected %0d, got %0d",
                               pixels_checked, want.green, got.green));
      if (got.blue !== want.blue)
        note_failure($sformatf("result %0d blue: expected %0d, got %0d",
                               pixels_checked, want.blue, got.blue));
      if (got.dither !== want.dither)
        note_failure($sformatf("result %0d dither: expected %0h, got %0h",
                               pixels_checked, want.dither, got.dither));
      if (got.luma !== want.luma)
        note_failure($sformatf("result %0d luma: expected %0d, got %0d",
                               pixels_checked, want.luma, got.luma));
      if (got.u_val !== want.u_val)
        note_failure($sformatf("result %0d u: expected %0d, got %0d",
                               pixels_checked, want.u_val, got.u_val));
      if (got.v_val !== want.v_val)
        note_failure($sformatf("result %0d v: expected %0d, got %0d",
                               pixels_checked, want.v_val, got.v_val));
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [1:0]         cfg_idx_i;
  logic [10:0]        cfg_data_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic               command_i;
  logic [7:0]         gamma_index_i;
  logic [7:0]         gamma_value_i;
  logic [3:0]         first_color_i;
  logic [3:0]         second_color_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [7:0]         red_o;
  logic [7:0]         green_o;
  logic [7:0]         blue_o;
  logic [3:0]         dither_code_o;
  logic signed [18:0] luma_scaled_o;
  logic signed [15:0] u_scaled_o;
  logic signed [15:0] v_scaled_o;

  rgb_conversion_tracker tracker = new();

  // Flags shared by the sender and the result stall process.
  bit long_hold  = 1'b0;
  bit hold_done  = 1'b0;
  bit quiet_tail = 1'b0;
  int settings_used = 1;

  palette_yuv_to_rgb_gamma_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .gamma_index_i  (gamma_index_i),
    .gamma_value_i  (gamma_value_i),
    .first_color_i  (first_color_i),
    .second_color_i (second_color_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .red_o          (red_o),
    .green_o        (green_o),
    .blue_o         (blue_o),
    .dither_code_o  (dither_code_o),
    .luma_scaled_o  (luma_scaled_o),
    .u_scaled_o     (u_scaled_o),
    .v_scaled_o     (v_scaled_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Offers one transaction, starting at a falling edge, and returns at the
  // falling edge after it was accepted. A random burst of idle cycles may come
  // first, except during the long output hold and in the quiet tail.
  task automatic push_item(input cmd_e cmd, input logic [7:0] gidx, input logic [7:0] gval,
                           input logic [3:0] fc, input logic [3:0] sc);
    if (!long_hold && !quiet_tail && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    command_i      <= cmd;
    gamma_index_i  <= gidx;
    gamma_value_i  <= gval;
    first_color_i  <= fc;
    second_color_i <= sc;
    do @(posedge clk_i); while (in_stall_o);
    tracker.accept_item(cmd, gidx, gval, fc, sc);
    @(negedge clk_i);
  endtask

  // A convert must never read a gamma entry that was never loaded, so any
  // in-range level it is going to use is loaded first with a random value.
  task automatic ensure_loaded(input longint lvl);
    if (lvl >= 0 && lvl <= 255 && !tracker.gamma_loaded[lvl[7:0]])
      push_item(CmdLoad, lvl[7:0], 8'($urandom()), 4'($urandom()), 4'($urandom()));
  endtask

  task automatic send_convert(input logic [3:0] fc, input logic [3:0] sc);
    pixel_t px;
    longint lvl_r, lvl_g, lvl_b;
    tracker.convert_pair(fc, sc, px, lvl_r, lvl_g, lvl_b);
    ensure_loaded(lvl_r);
    ensure_loaded(lvl_g);
    ensure_loaded(lvl_b);
    push_item(CmdConvert, 8'($urandom()), 8'($urandom()), fc, sc);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [10:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    tracker.set_reg(idx, value);
    @(negedge clk_i);
  endtask

  task automatic write_settings(input logic [10:0] sat, input logic [10:0] con,
                                input logic [10:0] bri, input logic sel);
    write_reg(CfgSaturation, sat);
    write_reg(CfgContrast, con);
    write_reg(CfgBrightness, bri);
    write_reg(CfgLumaSelect, {10'd0, sel});
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    settings_used++;
  endtask

  // Waits until every predicted pixel has come back, then lets trailing load
  // transactions leave the pipeline before the registers may change.
  task automatic settle();
    int waited;
    waited = 0;
    in_valid_i <= 1'b0;
    while (tracker.expected_pixels.size() != 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Gains are mostly drawn from the legal range, with the extremes and the
  // values above the range mixed in.
  function automatic logic [10:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return 11'd0;
      1:       return 11'd2000;
      2:       return 11'd2047;
      default: return 11'($urandom_range(0, 2000));
    endcase
  endfunction

  // Each transaction that leaves the unit is checked at the edge that moves it.
  always @(posedge clk_i) begin : result_monitor
    pixel_t seen;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen.red    = red_o;
      seen.green  = green_o;
      seen.blue   = blue_o;
      seen.dither = dither_code_o;
      seen.luma   = luma_scaled_o;
      seen.u_val  = u_scaled_o;
      seen.v_val  = v_scaled_o;
      tracker.check_pixel(seen);
    end
  end

  // Result side back-pressure: short random bursts, plus one long hold once
  // enough results have been seen, long enough for the pipeline to fill and
  // push back on the input side.
  initial begin : result_stall
    int held;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!hold_done && !quiet_tail && tracker.pixels_checked >= 150) begin
        hold_done   = 1'b1;
        long_hold   = 1'b1;
        out_stall_i <= 1'b1;
        for (held = 0; held < LONG_HOLD_CYCLES; held++) @(negedge clk_i);
        long_hold   = 1'b0;
        out_stall_i <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    int phase;
    int n;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CfgSaturation;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    command_i      = CmdLoad;
    gamma_index_i  = '0;
    gamma_value_i  = '0;
    first_color_i  = '0;
    second_color_i = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part under the reset register values: gamma loads at the index
    // and value extremes, then pairs that cover every color, both clamps
    // (white overflows, black with strong negative chroma underflows) and
    // the chroma average of opposite colors.
    push_item(CmdLoad, 8'hFF, 8'h00, 4'h0, 4'hF);
    push_item(CmdLoad, 8'h00, 8'hFF, 4'hF, 4'h0);
    push_item(CmdLoad, 8'hAA, 8'h55, 4'h5, 4'hA);
    push_item(CmdLoad, 8'h55, 8'hAA, 4'hA, 4'h5);
    foreach (DIRECTED_PAIRS[i])
      send_convert(DIRECTED_PAIRS[i][7:4], DIRECTED_PAIRS[i][3:0]);
    settle();

    // Random part: one register setting per phase, the first few fixed at the
    // extremes, the rest drawn at random. The last phase runs without idling.
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0:       write_settings(11'd2000, 11'd2000, 11'd2000, 1'b1);
        1:       write_settings(11'd0, 11'd0, 11'd0, 1'b0);
        2:       write_settings(11'd2047, 11'd2047, 11'd2047, 1'b0);
        3:       write_settings(11'd0, 11'd2000, 11'd0, 1'b1);
        default: write_settings(pick_gain(), pick_gain(), pick_gain(), 1'($urandom()));
      endcase
      quiet_tail = (phase == RANDOM_PHASES - 1);
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(0, 3) == 0)
          push_item(CmdLoad, 8'($urandom()), 8'($urandom()), 4'($urandom()), 4'($urandom()));
        else
          send_convert(4'($urandom()), 4'($urandom()));
      end
      settle();
    end

    // Anything still expected after the drain never arrived.
    while (tracker.expected_pixels.size() != 0) begin
      void'(tracker.expected_pixels.pop_front());
      tracker.note_failure("expected result never arrived");
    end

    $display("Checked %0d conversions and %0d gamma loads under %0d register settings.",
             tracker.converts_seen, tracker.loads_seen, settings_used);
    $display("Output was held %0d cycles once while inputs kept coming.", LONG_HOLD_CYCLES);
    if (tracker.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin : watchdog
    #8_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/pyrg_pkg.sv
hw/rtl/palette_yuv_to_rgb_gamma_unit.sv
hw/rtl/pyrg_checker.sv
bench/palette_yuv_to_rgb_gamma_unit_test.sv
